>>> sv/rupsc_pkg.sv
// Shared types and constants for the rectangle-update prefix-sum counter.
`default_nettype none

package rupsc_pkg;

  // field widths
  localparam int CMD_W     = 2;
  localparam int COORD_W   = 6;
  localparam int AMT_W     = 16;
  localparam int CNT_W     = 13;
  localparam int DIM_CFG_W = 7;
  localparam int CFG_IDX_W = 1;

  // delta values and the wider accumulator of the shared adder
  localparam int DATA_W = 32;
  localparam int ACC_W  = 35;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 7'd64;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] left_col;
    logic [COORD_W-1:0] bottom_row;
    logic [COORD_W-1:0] right_col;
    logic [AMT_W-1:0]   amount;
    logic               is_repair;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] survivor_count;
    logic             range_error;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/rupsc_alu.sv
// Shared adder/subtractor with 32-bit signed saturation and a positive test.
`default_nettype none

module rupsc_alu (
  input  logic signed [rupsc_pkg::ACC_W-1:0]  op_a,
  input  logic signed [rupsc_pkg::ACC_W-1:0]  op_b,
  input  logic                                sub,
  output logic signed [rupsc_pkg::ACC_W-1:0]  sum,
  output logic signed [rupsc_pkg::DATA_W-1:0] sat,
  output logic                                pos
);

  localparam int AW = rupsc_pkg::ACC_W;
  localparam int DW = rupsc_pkg::DATA_W;

  localparam logic signed [AW-1:0] SAT_MAX = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_MIN = {{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  // one add or subtract per cycle
  assign sum = sub ? (op_a - op_b) : (op_a + op_b);

  // clip to the signed 32-bit range
  always_comb begin
    if (sum > SAT_MAX) begin
      sat = SAT_MAX[DW-1:0];
    end else if (sum < SAT_MIN) begin
      sat = SAT_MIN[DW-1:0];
    end else begin
      sat = sum[DW-1:0];
    end
  end

  assign pos = !sum[AW-1] && (|sum);

endmodule

`default_nettype wire

>>> sv/rupsc_cfg.sv
// Row and column count registers with clamping to the usable grid.
`default_nettype none

module rupsc_cfg #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int DIM_W    = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rupsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rupsc_pkg::DIM_CFG_W-1:0]      cfg_data,
  output logic [DIM_W-1:0]                     rows_eff,
  output logic [DIM_W-1:0]                     cols_eff
);

  logic [rupsc_pkg::DIM_CFG_W-1:0] row_count_r;
  logic [rupsc_pkg::DIM_CFG_W-1:0] col_count_r;
  logic [DIM_W-1:0]                row_ext;
  logic [DIM_W-1:0]                col_ext;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= rupsc_pkg::DIM_RESET;
      col_count_r <= rupsc_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rupsc_pkg::CFG_ROW_COUNT: row_count_r <= cfg_data;
        rupsc_pkg::CFG_COL_COUNT: col_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  assign row_ext = DIM_W'(row_count_r);
  assign col_ext = DIM_W'(col_count_r);

  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = DIM_W'(1);
    end else if (row_ext > DIM_W'(MAX_ROWS)) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end else begin
      rows_eff = row_ext;
    end
    if (col_count_r == '0) begin
      cols_eff = DIM_W'(1);
    end else if (col_ext > DIM_W'(MAX_COLS)) begin
      cols_eff = DIM_W'(MAX_COLS);
    end else begin
      cols_eff = col_ext;
    end
  end

endmodule

`default_nettype wire

>>> sv/rect_update_prefix_sum_counter.sv
// Top level: grid stores, command sequencer and the shared adder around them.
//
// Usage: items enter on in_valid/in_ready as in_item_t beats. A load (command 0)
// writes one base cell. A rectangle update (command 1) marks up to four
// corners of the difference grid; each corner that lies inside the grid is
// read and then added to, each one beyond it is skipped. A compute (command 2)
// walks all MAX_ROWS*MAX_COLS cells: each cell inside the grid in use is read,
// then takes three adds and one compare on the shared adder; each cell outside
// it is only cleared, and the result is posted at the end. Only compute returns a
// beat on out_valid/out_ready (survivor count and the sticky range error).
// Command 3 is dropped. The block takes one item at a time; in_ready is high
// only between items.
// Reset: the delta store is cleared by a pass over all MAX_ROWS*MAX_COLS cells
// (4096 at the default size) with in_ready low; configuration writes on
// cfg_valid/cfg_ready are taken at any time. The base store holds no reset.
// A stalled receiver holds the result in the output register; a following
// compute waits at its end until that beat is taken.
`default_nettype none

module rect_update_prefix_sum_counter #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rupsc_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rupsc_pkg::out_item_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rupsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rupsc_pkg::DIM_CFG_W-1:0]     cfg_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DRW   = $clog2(MAX_ROWS + 1);
  localparam int DCW   = $clog2(MAX_COLS + 1);
  localparam int DW0   = (DRW > DCW) ? DRW : DCW;
  localparam int DIM_W = (DW0 > rupsc_pkg::DIM_CFG_W) ? DW0 : rupsc_pkg::DIM_CFG_W;
  localparam int PW    = AW + rupsc_pkg::DIM_CFG_W + 1;
  localparam int XW    = rupsc_pkg::ACC_W;
  localparam int DTW   = rupsc_pkg::DATA_W;
  localparam int CNTW  = rupsc_pkg::CNT_W;

  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(MAX_COLS - 1);

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_U_RD  = 4'd2;
  localparam logic [3:0] S_U_ADD = 4'd3;
  localparam logic [3:0] S_C_RD  = 4'd4;
  localparam logic [3:0] S_C_S1  = 4'd5;
  localparam logic [3:0] S_C_S2  = 4'd6;
  localparam logic [3:0] S_C_S3  = 4'd7;
  localparam logic [3:0] S_C_S4  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // corner order of a rectangle update
  localparam logic [1:0] K_TL = 2'd0;
  localparam logic [1:0] K_BR = 2'd1;
  localparam logic [1:0] K_BL = 2'd2;
  localparam logic [1:0] K_TR = 2'd3;

  function automatic logic [AW-1:0] cell_addr(
    input logic [rupsc_pkg::DIM_CFG_W-1:0] r,
    input logic [rupsc_pkg::DIM_CFG_W-1:0] c
  );
    logic [PW-1:0] p;
    p = PW'(r) * PW'(MAX_COLS) + PW'(c);
    return p[AW-1:0];
  endfunction

  // registers
  logic [3:0]                state_r, state_nxt;
  logic [1:0]                k_r, k_nxt;
  logic [AW-1:0]             addr_r, addr_nxt;
  logic [RW-1:0]             row_r, row_nxt;
  logic [CW-1:0]             col_r, col_nxt;
  logic signed [XW-1:0]      acc_r, acc_nxt;
  logic signed [DTW-1:0]     up_r, up_nxt;
  logic signed [DTW-1:0]     left_r, left_nxt;
  logic signed [DTW-1:0]     diag_r, diag_nxt;
  logic signed [DTW-1:0]     p_r, p_nxt;
  logic [CNTW-1:0]           cnt_r, cnt_nxt;
  logic                      err_r, err_nxt;
  logic                      out_valid_r, out_valid_nxt;
  rupsc_pkg::out_item_t      out_data_r, out_data_nxt;
  rupsc_pkg::in_item_t       item_r, item_nxt;

  // memories
  logic [DTW-1:0]                 delta_mem [CELLS];
  logic [rupsc_pkg::AMT_W-1:0]    base_mem  [CELLS];
  logic [DTW-1:0]                 rowbuf_mem [MAX_COLS];
  logic signed [DTW-1:0]          d_q_r;
  logic [rupsc_pkg::AMT_W-1:0]    b_q_r;
  logic signed [DTW-1:0]          rb_q_r;

  logic                           d_we;
  logic [AW-1:0]                  d_waddr;
  logic [DTW-1:0]                 d_wdata;
  logic [AW-1:0]                  d_raddr;
  logic                           b_we;
  logic [AW-1:0]                  b_waddr;
  logic                           rb_we;

  // config
  logic [DIM_W-1:0]               rows_eff;
  logic [DIM_W-1:0]               cols_eff;

  // alu
  logic signed [XW-1:0]           alu_a;
  logic signed [XW-1:0]           alu_b;
  logic                           alu_sub;
  logic signed [XW-1:0]           alu_sum;
  logic signed [DTW-1:0]          alu_sat;
  logic                           alu_pos;

  // misc
  logic                           in_acc;
  logic                           last_cell;
  logic                           in_region;
  logic                           load_ok;
  logic                           upd_ok;
  logic [rupsc_pkg::DIM_CFG_W-1:0] y1e, x1e, y2p, x2p;
  logic [rupsc_pkg::DIM_CFG_W-1:0] cr_row, cr_col;
  logic                           cr_en;
  logic                           cr_neg;
  logic [AW-1:0]                  cr_addr;
  logic signed [XW-1:0]           amt_ext;
  logic signed [DTW-1:0]          up_sel, left_sel, diag_sel;

  rupsc_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .DIM_W    (DIM_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rows_eff  (rows_eff),
    .cols_eff  (cols_eff)
  );

  rupsc_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum),
    .sat  (alu_sat),
    .pos  (alu_pos)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // range checks on the incoming beat
  assign load_ok = (DIM_W'(in_data.top_row) < rows_eff) &&
                   (DIM_W'(in_data.left_col) < cols_eff);
  assign upd_ok  = load_ok &&
                   (DIM_W'(in_data.bottom_row) < rows_eff) &&
                   (DIM_W'(in_data.right_col) < cols_eff);

  // corner selection for the held update
  assign y1e = rupsc_pkg::DIM_CFG_W'(item_r.top_row);
  assign x1e = rupsc_pkg::DIM_CFG_W'(item_r.left_col);
  assign y2p = rupsc_pkg::DIM_CFG_W'(item_r.bottom_row) + 1'b1;
  assign x2p = rupsc_pkg::DIM_CFG_W'(item_r.right_col) + 1'b1;

  always_comb begin
    unique case (k_r)
      K_TL: begin
        cr_row = y1e;
        cr_col = x1e;
        cr_en  = 1'b1;
        cr_neg = 1'b0;
      end
      K_BR: begin
        cr_row = y2p;
        cr_col = x2p;
        cr_en  = (DIM_W'(y2p) < rows_eff) && (DIM_W'(x2p) < cols_eff);
        cr_neg = 1'b0;
      end
      K_BL: begin
        cr_row = y2p;
        cr_col = x1e;
        cr_en  = (DIM_W'(y2p) < rows_eff);
        cr_neg = 1'b1;
      end
      default: begin
        cr_row = y1e;
        cr_col = x2p;
        cr_en  = (DIM_W'(x2p) < cols_eff);
        cr_neg = 1'b1;
      end
    endcase
  end

  assign cr_addr = cell_addr(cr_row, cr_col);
  assign amt_ext = {{(XW-rupsc_pkg::AMT_W){1'b0}}, item_r.amount};

  // walk position
  assign last_cell = (addr_r == LAST_ADDR);
  assign in_region = (DIM_W'(row_r) < rows_eff) && (DIM_W'(col_r) < cols_eff);

  // neighbors above the first row or left of the first column read as zero
  assign up_sel   = (row_r != '0) ? rb_q_r : '0;
  assign left_sel = (col_r != '0) ? left_r : '0;
  assign diag_sel = (col_r != '0) ? diag_r : '0;

  // shared adder operands
  always_comb begin
    alu_a   = acc_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_U_ADD: begin
        alu_a   = XW'(d_q_r);
        alu_b   = amt_ext;
        alu_sub = !(item_r.is_repair ^ cr_neg);
      end
      S_C_S1: begin
        alu_a = XW'(d_q_r);
        alu_b = XW'(up_sel);
      end
      S_C_S2: begin
        alu_b = XW'(left_sel);
      end
      S_C_S3: begin
        alu_b   = XW'(diag_sel);
        alu_sub = 1'b1;
      end
      S_C_S4: begin
        alu_a = XW'(p_r);
        alu_b = {{(XW-rupsc_pkg::AMT_W){1'b0}}, b_q_r};
      end
      default: ;
    endcase
  end

  // delta read address: corner during an update, walk position otherwise
  assign d_raddr = (state_r == S_U_RD) ? cr_addr : addr_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    addr_nxt      = addr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    acc_nxt       = acc_r;
    up_nxt        = up_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    item_nxt      = item_r;
    d_we          = 1'b0;
    d_waddr       = addr_r;
    d_wdata       = '0;
    b_we          = 1'b0;
    b_waddr       = cell_addr(rupsc_pkg::DIM_CFG_W'(in_data.top_row),
                              rupsc_pkg::DIM_CFG_W'(in_data.left_col));
    rb_we         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // post-reset clearing pass over the delta store
      S_CLR: begin
        d_we     = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (last_cell) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          item_nxt = in_data;
          unique case (in_data.command)
            rupsc_pkg::CMD_LOAD: begin
              if (load_ok) begin
                b_we = 1'b1;
              end else begin
                err_nxt = 1'b1;
              end
            end
            rupsc_pkg::CMD_UPDATE: begin
              if (upd_ok) begin
                k_nxt     = K_TL;
                state_nxt = S_U_RD;
              end else begin
                err_nxt = 1'b1;
              end
            end
            rupsc_pkg::CMD_COMPUTE: begin
              cnt_nxt   = '0;
              addr_nxt  = '0;
              row_nxt   = '0;
              col_nxt   = '0;
              state_nxt = S_C_RD;
            end
            default: ;
          endcase
        end
      end

      // corner read, skipped when the corner falls beyond the grid
      S_U_RD: begin
        if (cr_en) begin
          state_nxt = S_U_ADD;
        end else if (k_r == K_TR) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // corner add with saturation, written back
      S_U_ADD: begin
        d_we    = 1'b1;
        d_waddr = cr_addr;
        d_wdata = alu_sat;
        if (k_r == K_TR) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_U_RD;
        end
      end

      // cells outside the grid in use are only cleared
      S_C_RD: begin
        if (in_region) begin
          state_nxt = S_C_S1;
        end else begin
          d_we     = 1'b1;
          addr_nxt = addr_r + 1'b1;
          if (col_r == LAST_COL) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
          if (last_cell) begin
            state_nxt = S_DONE;
          end
        end
      end

      // delta plus up; the cell is cleared as it is consumed
      S_C_S1: begin
        acc_nxt   = alu_sum;
        up_nxt    = up_sel;
        d_we      = 1'b1;
        state_nxt = S_C_S2;
      end

      S_C_S2: begin
        acc_nxt   = alu_sum;
        state_nxt = S_C_S3;
      end

      // minus diagonal, saturate, keep for right and below
      S_C_S3: begin
        p_nxt     = alu_sat;
        left_nxt  = alu_sat;
        diag_nxt  = up_r;
        rb_we     = 1'b1;
        state_nxt = S_C_S4;
      end

      // base plus prefix sum above zero
      S_C_S4: begin
        if (alu_pos) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        addr_nxt = addr_r + 1'b1;
        if (col_r == LAST_COL) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        state_nxt = last_cell ? S_DONE : S_C_RD;
      end

      S_DONE: begin
        addr_nxt = '0;
        row_nxt  = '0;
        col_nxt  = '0;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.survivor_count = cnt_r;
          out_data_nxt.range_error    = err_r;
          state_nxt                   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      k_r         <= K_TL;
      addr_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      addr_r      <= addr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    up_r       <= up_nxt;
    left_r     <= left_nxt;
    diag_r     <= diag_nxt;
    p_r        <= p_nxt;
    out_data_r <= out_data_nxt;
    item_r     <= item_nxt;
  end

  // delta store
  always_ff @(posedge clk) begin
    if (d_we) begin
      delta_mem[d_waddr] <= d_wdata;
    end
    d_q_r <= delta_mem[d_raddr];
  end

  // base store
  always_ff @(posedge clk) begin
    if (b_we) begin
      base_mem[b_waddr] <= in_data.amount;
    end
    b_q_r <= base_mem[addr_r];
  end

  // prefix sums of the row above
  always_ff @(posedge clk) begin
    if (rb_we) begin
      rowbuf_mem[col_r] <= alu_sat;
    end
    rb_q_r <= rowbuf_mem[col_r];
  end

  // checks
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result posted outside the done state");

  a_math_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_C_S1) |-> in_region)
    else $error("prefix-sum step on a cell outside the grid in use");

  a_corner_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_U_RD && cr_en) |=> (state_r == S_U_ADD && $stable(k_r)))
    else $error("corner read not followed by its add");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("range error flag dropped");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR || state_r == S_C_RD || state_r == S_U_RD) |-> !in_ready)
    else $error("input taken while busy");

endmodule

`default_nettype wire
